[hdl/ssc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    localparam int DATA_W = 32;
    localparam int ERR_W  = 33;
    localparam int ADDR_W = 3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic REG_SETPOINT = 1'b0;
    localparam logic REG_GAIN     = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } ssc_state_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic signed [DATA_W-1:0] a;
        logic signed [ERR_W-1:0]  b;
    } mac_op_t;

    typedef struct packed {
        logic                     valid;
        logic                     clip;
        logic signed [DATA_W-1:0] value;
    } mac_res_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] gain;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/ssc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ssc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] measurement;

    modport source (output valid, action, coef_index, coef_value, measurement, input ready);
    modport sink   (input valid, action, coef_index, coef_value, measurement, output ready);
endinterface

`default_nettype wire

[hdl/ssc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ssc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               clipped;

    modport source (output valid, drive, clipped, input ready);
    modport sink   (input valid, drive, clipped, output ready);
endinterface

`default_nettype wire

[hdl/ssc_apb_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssc_apb_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ssc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output ssc_pkg::cfg_t                   cfg
);
    import ssc_pkg::*;

    logic signed [DATA_W-1:0] setpoint_reg;
    logic signed [DATA_W-1:0] gain_reg;
    logic                     reg_idx;
    logic                     wr_en;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            gain_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SETPOINT: setpoint_reg <= pwdata;
                REG_GAIN:     gain_reg     <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SETPOINT: prdata = setpoint_reg;
            REG_GAIN:     prdata = gain_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.setpoint = setpoint_reg;
    assign cfg.gain     = gain_reg;

endmodule

`default_nettype wire

[hdl/ssc_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssc_mac #(
    parameter int ORDER     = 2,
    parameter int FRAC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssc_pkg::mac_op_t op,
    output ssc_pkg::mac_res_t     res
);
    import ssc_pkg::*;

    localparam int PROD_W = DATA_W + ERR_W;
    localparam int ACC_W  = PROD_W + $clog2(ORDER + 1);

    logic                    p_valid_reg;
    logic                    p_first_reg;
    logic                    p_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                    done_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic                    fits;

    assign prod_next = PROD_W'(op.a) * PROD_W'(op.b);
    assign acc_next  = (p_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_first_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= op.valid;
            p_first_reg <= op.first;
            p_last_reg  <= op.last;
            done_reg    <= p_valid_reg && p_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // The arithmetic shift truncates towards minus infinity; the sum fits when
    // every bit from the sign of the 32-bit result upwards agrees.
    assign shifted = acc_reg >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

    assign res.valid = done_reg;
    assign res.clip  = !fits;
    assign res.value = fits ? shifted[DATA_W-1:0] : (acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

`default_nettype wire

[hdl/state_space_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

// Discrete state-space controller in signed fixed point.
// Input channel in_ch carries either a coefficient load (action low) or a
// control step (action high). A load gives no transfer on the output. A
// step forms e = setpoint - measurement, then one shared multiply-accumulate
// unit works through (ORDER+1)*(ORDER+1) products: first the drive
// C*x + D*e, then each new state row A*x + B*e, all from the old state.
// in_ch is not ready while a step is in progress and becomes ready in the
// same cycle as the result appears, so a new step is not accepted until the
// previous one has finished.
// The result (drive and the clipped flag) waits in an output register. If
// out_ch stalls, the next step completes internally and then holds, with the
// state not yet updated, until the earlier result has been transferred.
// The user must write setpoint and feedthrough gain over the APB port only
// while idle; the block itself does not enforce this.
// Reset clears the state vector, the coefficient store and both registers.
module state_space_controller #(
    parameter int ORDER     = 2,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ssc_in_if.sink                          in_ch,
    ssc_out_if.source                       out_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ssc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ssc_pkg::*;

    localparam int COEF_COUNT  = ORDER * ORDER + 2 * ORDER;
    localparam int B_BASE      = ORDER * ORDER;
    localparam int C_BASE      = ORDER * ORDER + ORDER;
    // Only slots reachable by the 3-bit index are stored; the rest stay zero.
    localparam int STORE_DEPTH = (COEF_COUNT < 8) ? COEF_COUNT : 8;
    localparam int SIDX_W      = $clog2(STORE_DEPTH);
    localparam int SLOT_W      = $clog2(COEF_COUNT);
    localparam int CNT_W       = $clog2(ORDER + 1);
    localparam int XIDX_W      = (ORDER > 1) ? $clog2(ORDER) : 1;

    cfg_t     cfg;
    mac_op_t  op;
    mac_res_t res;

    ssc_state_t state_reg, state_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic [SLOT_W-1:0] gslot_reg, gslot_next;
    logic [CNT_W-1:0]  res_row_reg;
    logic [CNT_W-1:0]  res_row_m1;

    logic signed [DATA_W-1:0] store_reg [STORE_DEPTH];
    logic signed [DATA_W-1:0] x_reg     [ORDER];
    logic signed [DATA_W-1:0] nx_reg    [ORDER];
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [DATA_W-1:0] drive_acc_reg;
    logic                     clip_acc_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_out_reg;
    logic                     clipped_out_reg;

    logic                     in_ready;
    logic                     in_xfer;
    logic                     start;
    logic                     commit;
    logic                     load_en;
    logic [SLOT_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_val;
    logic [XIDX_W-1:0]        x_idx;
    logic signed [DATA_W-1:0] x_sel;
    logic                     col_last;

    ssc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssc_mac #(
        .ORDER     (ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .res   (res)
    );

    assign in_ch.ready = in_ready;
    assign in_xfer     = in_ch.valid && in_ready;
    assign load_en     = in_xfer && (in_ch.action == ACT_LOAD)
                         && ({1'b0, in_ch.coef_index} < 4'(STORE_DEPTH));

    // Operand selection: one store read per cycle, either the matrix entry
    // for this column or, on the error column, the B entry of this row (the gain D on the drive row).
    assign col_last = (col_reg == CNT_W'(ORDER));
    assign rd_addr  = col_last ? gslot_reg : (base_reg + SLOT_W'(col_reg));
    assign rd_val   = ({1'b0, rd_addr} < (SLOT_W + 1)'(STORE_DEPTH))
                      ? store_reg[rd_addr[SIDX_W-1:0]] : '0;
    assign x_idx    = col_last ? '0 : XIDX_W'(col_reg);
    assign x_sel    = x_reg[x_idx];

    always_comb
    begin
        op.valid = 1'b0;
        op.first = (col_reg == '0);
        op.last  = col_last;
        op.a     = (col_last && (row_reg == '0)) ? cfg.gain : rd_val;
        op.b     = col_last ? e_reg : {x_sel[DATA_W-1], x_sel};

        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        gslot_next = gslot_reg;
        in_ready   = 1'b0;
        start      = 1'b0;
        commit     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_ch.valid && (in_ch.action == ACT_STEP))
                begin
                    start      = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    base_next  = SLOT_W'(C_BASE);
                    gslot_next = SLOT_W'(B_BASE);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                op.valid = 1'b1;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_reg + CNT_W'(1);
                    if (row_reg == '0)
                    begin
                        base_next = '0;
                    end
                    else
                    begin
                        base_next  = base_reg + SLOT_W'(ORDER);
                        gslot_next = gslot_reg + SLOT_W'(1);
                    end
                    if (row_reg == CNT_W'(ORDER))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (res.valid && (res_row_reg == CNT_W'(ORDER)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            base_reg    <= '0;
            gslot_reg   <= '0;
            res_row_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            gslot_reg <= gslot_next;
            if (start)
            begin
                res_row_reg <= '0;
            end
            else if (res.valid)
            begin
                res_row_reg <= res_row_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (load_en)
        begin
            store_reg[in_ch.coef_index[SIDX_W-1:0]] <= in_ch.coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                x_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                x_reg[i] <= nx_reg[i];
            end
        end
    end

    // Results come back in row order: the drive first, then each new state.
    assign res_row_m1 = res_row_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            e_reg <= {cfg.setpoint[DATA_W-1], cfg.setpoint}
                     - {in_ch.measurement[DATA_W-1], in_ch.measurement};
        end
        if (res.valid)
        begin
            if (res_row_reg == '0)
            begin
                drive_acc_reg <= res.value;
            end
            else
            begin
                nx_reg[res_row_m1[XIDX_W-1:0]] <= res.value;
            end
        end
        if (commit)
        begin
            drive_out_reg   <= drive_acc_reg;
            clipped_out_reg <= clip_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_acc_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                clip_acc_reg <= 1'b0;
            end
            else if (res.valid && res.clip)
            begin
                clip_acc_reg <= 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.drive   = drive_out_reg;
    assign out_ch.clipped = clipped_out_reg;

endmodule

`default_nettype wire
